// ----- sv/pts_pkg.sv -----
// Package with shared types and constants of the brightness sort core.
package pts_pkg;

  localparam int unsigned PIX_W = 24;
  localparam int unsigned THR_W = 10;
  localparam int unsigned KEY_W = 11;
  localparam logic [KEY_W-1:0] DIM_KEY = 11'd1024;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } st_e;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [PIX_W-1:0] pixel;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic drain;
  } cell_ctrl_t;

  function automatic logic [KEY_W-1:0] key_of(input logic [PIX_W-1:0] pix,
                                              input logic [THR_W-1:0] thr);
    logic [THR_W-1:0] bright;
    bright = THR_W'(pix[7:0]) + THR_W'(pix[15:8]) + THR_W'(pix[23:16]);
    return (bright < thr) ? DIM_KEY : KEY_W'(bright);
  endfunction

endpackage

// ----- sv/pts_in_if.sv -----
// Input channel interface: one pixel per transfer.
interface pts_in_if
  import pts_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             last;

  modport source (output valid, output pixel, output last, input ready);
  modport sink (input valid, input pixel, input last, output ready);
endinterface

// ----- sv/pts_out_if.sv -----
// Output channel interface: one sorted pixel per transfer.
interface pts_out_if
  import pts_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] sorted_pixel;
  logic             end_of_line;

  modport source (output valid, output sorted_pixel, output end_of_line, input ready);
  modport sink (input valid, input sorted_pixel, input end_of_line, output ready);
endinterface

// ----- sv/pixel_threshold_brightness_sort_core.sv -----
// Top level of the thresholded brightness sort core.
// Pixels of a line are taken one per cycle and inserted into a chain of MAX_LINE cells,
// kept ordered by key (brightness, or a dim mark that sorts after all bright pixels,
// ties in arrival order). The line ends at the pixel marked last or at the MAX_LINE-th
// pixel; the chain then drains from its head one pixel per cycle while out_o.ready is high,
// and no input is taken until the final pixel of the line has been transferred. The dim
// threshold is sampled as each pixel enters.
module pixel_threshold_brightness_sort_core
  import pts_pkg::*;
#(
  parameter int unsigned MAX_LINE = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [THR_W-1:0] cfg_wdata_i,
  pts_in_if.sink           in_i,
  pts_out_if.source        out_o
);

  localparam int unsigned CNT_W = $clog2(MAX_LINE + 1);

  logic [THR_W-1:0] thr_q;
  logic [CNT_W-1:0] fill_q, fill_d;
  st_e              state_q, state_d;
  cell_ctrl_t       ctrl;
  entry_t           new_entry;
  entry_t           cells [MAX_LINE];
  logic             ahead [MAX_LINE];
  logic             line_end;
  logic             out_xfer;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  assign new_entry.valid = 1'b1;
  assign new_entry.key   = key_of(in_i.pixel, thr_q);
  assign new_entry.pixel = in_i.pixel;

  assign ctrl.insert = in_i.valid && in_i.ready;
  assign out_xfer    = out_o.valid && out_o.ready;
  assign ctrl.drain  = out_xfer;
  assign line_end    = in_i.last || (fill_q == CNT_W'(MAX_LINE - 1));

  for (genvar g = 0; g < MAX_LINE; g++) begin : g_cell
    entry_t prev_e, next_e;
    logic   prev_b;
    if (g == 0) begin : g_head
      assign prev_e = new_entry;
      assign prev_b = 1'b0;
    end else begin : g_body
      assign prev_e = cells[g-1];
      assign prev_b = ahead[g-1];
    end
    if (g == MAX_LINE - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_mid
      assign next_e = cells[g+1];
    end
    pts_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .new_i         (new_entry),
      .prev_i        (prev_e),
      .prev_before_i (prev_b),
      .next_i        (next_e),
      .cell_o        (cells[g]),
      .before_o      (ahead[g])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_FILL: begin
        if (ctrl.insert && line_end) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (out_xfer && !cells[1].valid) state_d = ST_FILL;
      end
      default: state_d = ST_FILL;
    endcase
  end

  always_comb begin
    in_i.ready         = 1'b0;
    out_o.valid        = 1'b0;
    out_o.sorted_pixel = cells[0].pixel;
    out_o.end_of_line  = !cells[1].valid;
    case (state_q)
      ST_FILL:  in_i.ready  = 1'b1;
      ST_DRAIN: out_o.valid = cells[0].valid;
      default: begin
        in_i.ready  = 1'b0;
        out_o.valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    fill_d = fill_q;
    if (ctrl.insert) begin
      fill_d = line_end ? '0 : fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < CNT_W'(MAX_LINE))
    else $error("fill count out of range");

  a_head_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cells[0].valid && cells[1].valid) |-> (cells[0].key <= cells[1].key))
    else $error("chain head out of order");

  a_end_enters_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.insert && line_end) |=> (state_q == ST_DRAIN && out_o.valid))
    else $error("line end did not start drain");

  a_eol_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && out_o.end_of_line) |=> (state_q == ST_FILL && !cells[0].valid))
    else $error("chain not empty after end of line");

  a_fill_empty_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL) |-> !out_o.valid)
    else $error("output valid while filling");

endmodule

// ----- sv/pts_cell.sv -----
// One cell of the insertion chain: holds one keyed pixel.
module pts_cell
  import pts_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     new_i,
  input  entry_t     prev_i,
  input  logic       prev_before_i,
  input  entry_t     next_i,
  output entry_t     cell_o,
  output logic       before_o
);

  entry_t cell_q, cell_d;

  assign before_o = !cell_q.valid || (cell_q.key > new_i.key);

  always_comb begin
    cell_d = cell_q;
    if (ctrl_i.insert) begin
      if (before_o) begin
        cell_d = prev_before_i ? prev_i : new_i;
      end
    end else if (ctrl_i.drain) begin
      cell_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule
